// ===== hdl/sacache_pkg.sv =====
// Shared constants and types for the set-associative write-back cache model.
package sacache_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int DEF_MAX_SET_BITS = 10;
  localparam int DEF_MAX_WAYS     = 16;
  localparam int DEF_ADDR_BITS    = 64;

  // Field widths.
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 5;
  localparam int ADDRESS_W    = 64;
  localparam int CNT_W        = 32;
  localparam int OUTCOME_W    = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Stream words: command and address in, result fields out, padded to bytes.
  localparam int IN_BITS     = 1 + ADDRESS_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = OUTCOME_W + 2 + 5 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_index_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

endpackage

// ===== hdl/set_assoc_lru_writeback_cache_model_core.sv =====
// Set-associative write-back cache model with true LRU, one set row per memory entry.
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  command and address of one access
// m_*       out        m_tvalid/m_tready  outcome, flags and running counters
// cfg_*     in         cfg_we             set_bits, block_bits, ways
//
// An access runs through the accept with the set read, tag compare and
// victim search on the read row, then the row write-back and result load.
// One access is in flight at a time.
// Reset and every configuration write start a clearing pass over all set rows
// (one row a cycle) during which no access is accepted.
// A result waits in the output register; a stalled output holds the write-back.
module set_assoc_lru_writeback_cache_model_core #(
  parameter int MAX_SET_BITS = sacache_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacache_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS    = sacache_pkg::DEF_ADDR_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] command, [64:1] address
  input  logic [sacache_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] outcome, [2] line_dirtied, [3] evicted_dirty, [35:4] hit_count,
  // [67:36] miss_count, [99:68] eviction_count, [131:100] dirty_bytes_held,
  // [163:132] dirty_evicted_bytes
  output logic [sacache_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                               cfg_we,
  input  logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sacache_pkg::*;

  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROWS      = 1 << SET_W;
  localparam int RANK_W    = $clog2(MAX_WAYS + 1);
  localparam int LVL       = $clog2(MAX_WAYS);
  localparam int WAY_W     = (LVL > 0) ? LVL : 1;
  localparam int P2        = 1 << LVL;
  localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int DL_W      = $clog2(NUM_LINES + 1);
  localparam int HELD_W    = DL_W + CNT_W;
  localparam int SHIFT_W   = 6;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CMP, ST_UPD} state_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0]                dirty;
    logic [MAX_WAYS-1:0][RANK_W-1:0]    rank;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
  } row_t;

  state_t                   state;
  logic [SET_W-1:0]         clr_cnt;
  logic [SET_BITS_W-1:0]    set_bits;
  logic [BLOCK_BITS_W-1:0]  block_bits;
  logic [WAYS_W-1:0]        ways;
  logic [CNT_W-1:0]         hits_total;
  logic [CNT_W-1:0]         misses_total;
  logic [CNT_W-1:0]         evictions_total;
  logic [CNT_W-1:0]         dirty_evict_bytes_total;
  logic [DL_W-1:0]          dirty_line_total;

  // Access registers.
  logic                     r_store;
  logic [ADDR_BITS-1:0]     r_tag;
  logic [SET_W-1:0]         r_set;
  outcome_t                 c_outcome;
  logic [WAY_W-1:0]         c_sel;
  logic [RANK_W-1:0]        c_thr;
  logic                     c_evd;

  row_t                     mem [ROWS];
  row_t                     rd_row;
  row_t                     new_row;
  logic                     mem_we;
  logic [SET_W-1:0]         mem_waddr;
  row_t                     mem_wdata;

  logic                     accept;
  logic                     cfg_valid;
  logic                     can_load;
  logic [4:0]               sb_c;
  logic [RANK_W-1:0]        nw;
  logic [ADDR_BITS-1:0]     in_addr;
  logic [ADDR_BITS-1:0]     in_blk_shift;
  logic [SET_W-1:0]         in_set;
  logic [ADDR_BITS-1:0]     in_tag;

  logic [MAX_WAYS-1:0]      hit_vec;
  logic [MAX_WAYS-1:0]      inv_vec;
  logic [WAY_W-1:0]         hit_sel;
  logic [WAY_W-1:0]         inv_sel;
  logic [RANK_W-1:0]        rank_pad [P2];
  logic [RANK_W:0]          key      [LVL+1][P2];
  logic [WAY_W-1:0]         idx      [LVL+1][P2];

  logic                     sel_was_dirty;
  logic [DL_W-1:0]          dl_dec;
  logic [DL_W-1:0]          dl_next;
  logic [HELD_W-1:0]        held_wide;
  logic [CNT_W-1:0]         held;
  logic [CNT_W:0]           dev_sum;
  logic [CNT_W-1:0]         dev_next;
  logic [CNT_W-1:0]         hits_next;
  logic [CNT_W-1:0]         misses_next;
  logic [CNT_W-1:0]         evictions_next;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign can_load  = !m_tvalid || m_tready;
  assign cfg_valid = cfg_we && ((cfg_index == CFG_SET_BITS) || (cfg_index == CFG_BLOCK_BITS) ||
                                (cfg_index == CFG_WAYS));

  // Effective geometry after clamping.
  assign sb_c = (5'(set_bits) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : 5'(set_bits);
  assign nw   = (ways == '0) ? RANK_W'(1) :
                ((32'(ways) > 32'(MAX_WAYS)) ? RANK_W'(MAX_WAYS) : RANK_W'(ways));

  // Address split of the incoming word.
  assign in_addr      = s_tdata[ADDR_BITS:1];
  assign in_blk_shift = in_addr >> block_bits;
  assign in_set       = in_blk_shift[SET_W-1:0] & ~({SET_W{1'b1}} << sb_c);
  assign in_tag       = in_addr >> (SHIFT_W'(sb_c) + SHIFT_W'(block_bits));

  // Set memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= mem[in_set];
    end
  end

  assign mem_we    = (state == ST_CLEAR) || ((state == ST_UPD) && can_load);
  assign mem_waddr = (state == ST_CLEAR) ? clr_cnt : r_set;
  assign mem_wdata = (state == ST_CLEAR) ? row_t'('0) : new_row;

  // Tag compare and empty-way detection over the ways in use.
  genvar gw;
  generate
    for (gw = 0; gw < MAX_WAYS; gw++) begin : g_way
      assign hit_vec[gw] = (RANK_W'(gw) < nw) && rd_row.valid[gw] && (rd_row.tag[gw] == r_tag);
      assign inv_vec[gw] = (RANK_W'(gw) < nw) && !rd_row.valid[gw];
    end
    for (gw = 0; gw < P2; gw++) begin : g_pad
      if (gw < MAX_WAYS) begin : g_real
        assign rank_pad[gw] = rd_row.rank[gw];
      end else begin : g_fill
        assign rank_pad[gw] = '0;
      end
    end
  endgenerate

  always_comb begin
    hit_sel = '0;
    inv_sel = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_sel = WAY_W'(w);
      if (inv_vec[w]) inv_sel = WAY_W'(w);
    end
  end

  // Victim search: a min tree on rank; the left side wins ties, giving the lowest way.
  always_comb begin
    for (int i = 0; i < P2; i++) begin
      key[0][i] = (i < 32'(nw)) ? {1'b0, rank_pad[i]} : {(RANK_W + 1){1'b1}};
      idx[0][i] = WAY_W'(i);
    end
    for (int l = 1; l <= LVL; l++) begin
      for (int i = 0; i < P2; i++) begin
        key[l][i] = {(RANK_W + 1){1'b1}};
        idx[l][i] = '0;
        if (i < (P2 >> l)) begin
          if (key[l-1][2*i+1] < key[l-1][2*i]) begin
            key[l][i] = key[l-1][2*i+1];
            idx[l][i] = idx[l-1][2*i+1];
          end else begin
            key[l][i] = key[l-1][2*i];
            idx[l][i] = idx[l-1][2*i];
          end
        end
      end
    end
  end

  // Row update: lines ranked above the threshold step down, the chosen line becomes newest.
  always_comb begin
    new_row = rd_row;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if ((RANK_W'(k) < nw) && (WAY_W'(k) != c_sel) && rd_row.valid[k] &&
          (rd_row.rank[k] > c_thr)) begin
        new_row.rank[k] = rd_row.rank[k] - 1'b1;
      end
    end
    new_row.rank[c_sel]  = nw;
    new_row.valid[c_sel] = 1'b1;
    new_row.tag[c_sel]   = r_tag;
    if (c_outcome != OUT_HIT) new_row.dirty[c_sel] = 1'b0;
    if (r_store) new_row.dirty[c_sel] = 1'b1;
  end

  // Counter updates.
  assign sel_was_dirty  = (c_outcome == OUT_HIT) ? rd_row.dirty[c_sel] : 1'b0;
  assign dl_dec         = (c_evd && (dirty_line_total != '0)) ? dirty_line_total - 1'b1
                                                              : dirty_line_total;
  assign dl_next        = (r_store && !sel_was_dirty) ? dl_dec + 1'b1 : dl_dec;
  assign held_wide      = HELD_W'(dl_next) << block_bits;
  assign held           = (|held_wide[HELD_W-1:CNT_W]) ? {CNT_W{1'b1}} : held_wide[CNT_W-1:0];
  assign dev_sum        = {1'b0, dirty_evict_bytes_total} + ((CNT_W + 1)'(1) << block_bits);
  assign dev_next       = !c_evd ? dirty_evict_bytes_total :
                          (dev_sum[CNT_W] ? {CNT_W{1'b1}} : dev_sum[CNT_W-1:0]);
  assign hits_next      = ((c_outcome == OUT_HIT) && !(&hits_total)) ? hits_total + 1'b1
                                                                    : hits_total;
  assign misses_next    = ((c_outcome != OUT_HIT) && !(&misses_total)) ? misses_total + 1'b1
                                                                      : misses_total;
  assign evictions_next = ((c_outcome == OUT_EVICT) && !(&evictions_total))
                          ? evictions_total + 1'b1 : evictions_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= ST_CLEAR;
      clr_cnt                 <= '0;
      set_bits                <= '0;
      block_bits              <= '0;
      ways                    <= WAYS_W'(1);
      hits_total              <= '0;
      misses_total            <= '0;
      evictions_total         <= '0;
      dirty_evict_bytes_total <= '0;
      dirty_line_total        <= '0;
      m_tvalid                <= 1'b0;
    end else begin
      // In the write-back cycle a taken result is replaced by the new one below.
      if (m_tvalid && m_tready && ((state != ST_UPD) || cfg_valid)) m_tvalid <= 1'b0;
      if (cfg_valid) begin
        // A register write flushes every line and restarts the clearing pass.
        case (cfg_index)
          CFG_SET_BITS:   set_bits   <= cfg_data[SET_BITS_W-1:0];
          CFG_BLOCK_BITS: block_bits <= cfg_data[BLOCK_BITS_W-1:0];
          CFG_WAYS:       ways       <= cfg_data[WAYS_W-1:0];
          default:        ways       <= ways;
        endcase
        state            <= ST_CLEAR;
        clr_cnt          <= '0;
        dirty_line_total <= '0;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (&clr_cnt) state <= ST_IDLE;
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              r_store <= s_tdata[0];
              r_tag   <= in_tag;
              r_set   <= in_set;
              state   <= ST_CMP;
            end
          end
          ST_CMP: begin
            if (|hit_vec) begin
              c_outcome <= OUT_HIT;
              c_sel     <= hit_sel;
              c_thr     <= rd_row.rank[hit_sel];
              c_evd     <= 1'b0;
            end else if (|inv_vec) begin
              c_outcome <= OUT_FILL;
              c_sel     <= inv_sel;
              c_thr     <= '0;
              c_evd     <= 1'b0;
            end else begin
              c_outcome <= OUT_EVICT;
              c_sel     <= idx[LVL][0];
              c_thr     <= key[LVL][0][RANK_W-1:0];
              c_evd     <= rd_row.dirty[idx[LVL][0]];
            end
            state <= ST_UPD;
          end
          ST_UPD: begin
            if (can_load) begin
              hits_total              <= hits_next;
              misses_total            <= misses_next;
              evictions_total         <= evictions_next;
              dirty_evict_bytes_total <= dev_next;
              dirty_line_total        <= dl_next;
              m_tdata  <= {(OUT_TDATA_W - OUT_BITS)'(0), dev_next, held, evictions_next,
                           misses_next, hits_next, c_evd, r_store, c_outcome};
              m_tvalid <= 1'b1;
              state    <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // Tags within one set are unique, so at most one way can match.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> $onehot0(hit_vec))
    else $error("more than one way matched the tag");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_valid) |=> (state == ST_CMP))
    else $error("accepted word did not move to compare");

  a_result_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_UPD))
    else $error("result raised outside the write-back cycle");

  a_dirty_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(dirty_line_total) <= NUM_LINES))
    else $error("dirty line count exceeds the number of lines");

endmodule
